[rtl/kc3_pkg.sv]
package kc3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 10;
    localparam int MODE_W  = 2;
    localparam int IMG_W_W = 11;

    localparam logic [MODE_W-1:0] MODE_BOX     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GAUSS   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OUTLINE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SHARPEN = 2'd3;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_WIDTH = 1'b1;

    localparam logic [MODE_W-1:0]  MODE_RST  = MODE_BOX;
    localparam logic [IMG_W_W-1:0] WIDTH_RST = 11'd1024;

    // floor(s / 9) == (s * RECIP9) >> RECIP9_SH for s below 2296
    localparam logic [12:0] RECIP9    = 13'd7282;
    localparam int          RECIP9_SH = 16;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [IMG_W_W-1:0] image_width;
    } t_cfg;

    // p[row][col], row 0 top, col 0 left, centre at [1][1]
    typedef logic [2:0][2:0][PIX_W-1:0] t_win;

endpackage

[rtl/kc3_regs.sv]
module kc3_regs import kc3_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    logic [MODE_W-1:0]  r_mode;
    logic [IMG_W_W-1:0] r_width;
    logic               wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_RST;
            r_width <= WIDTH_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_MODE:  r_mode  <= pwdata[MODE_W-1:0];
                REG_WIDTH: r_width <= pwdata[IMG_W_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MODE:  prdata = 32'(r_mode);
            REG_WIDTH: prdata = 32'(r_width);
            default:   prdata = '0;
        endcase
    end

    assign o_cfg.mode        = r_mode;
    assign o_cfg.image_width = r_width;

endmodule

[rtl/kc3_line_buf.sv]
module kc3_line_buf import kc3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  logic [PIX_W-1:0]             i_wr_pix,
    output logic [PIX_W-1:0]             o_top,
    output logic [PIX_W-1:0]             o_mid,
    output logic                         o_busy
);

    localparam int AW = $clog2(MAX_WIDTH);

    // entry: {upper row pixel, middle row pixel}
    logic [2*PIX_W-1:0] mem [MAX_WIDTH];

    logic [2*PIX_W-1:0] r_rd;
    logic [2*PIX_W-1:0] r_byp_word;
    logic               r_byp;
    logic               r_clr;
    logic [AW-1:0]      r_clr_addr;
    logic [2*PIX_W-1:0] wr_word;
    logic [2*PIX_W-1:0] rd_word;

    assign rd_word = r_byp ? r_byp_word : r_rd;
    assign o_top   = rd_word[2*PIX_W-1:PIX_W];
    assign o_mid   = rd_word[PIX_W-1:0];
    assign wr_word = {o_mid, i_wr_pix};
    assign o_busy  = r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MAX_WIDTH - 1)) begin
                r_clr <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd       <= mem[i_rd_addr];
            r_byp_word <= wr_word;
        end
    end

    // forward a same-address write issued at the read edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

endmodule

[rtl/kc3_kernel.sv]
module kc3_kernel import kc3_pkg::*; (
    input  logic [MODE_W-1:0] i_mode,
    input  t_win              i_win,
    output logic [PIX_W-1:0]  o_value
);

    logic [9:0]         corners;
    logic [9:0]         edges;
    logic [PIX_W-1:0]   centre;
    logic [11:0]        box_sum;
    logic [24:0]        box_prod;
    logic [11:0]        gau_sum;
    logic [12:0]        out_pos;
    logic [12:0]        out_neg;
    logic signed [12:0] out_sum;
    logic [11:0]        shp_pos;
    logic signed [11:0] shp_sum;
    logic [PIX_W-1:0]   out_val;
    logic [PIX_W-1:0]   shp_val;

    always_comb begin
        corners  = 10'(i_win[0][0]) + 10'(i_win[0][2]) + 10'(i_win[2][0]) + 10'(i_win[2][2]);
        edges    = 10'(i_win[0][1]) + 10'(i_win[1][0]) + 10'(i_win[1][2]) + 10'(i_win[2][1]);
        centre   = i_win[1][1];

        box_sum  = 12'(corners) + 12'(edges) + 12'(centre);
        box_prod = 25'(box_sum) * 25'(RECIP9);

        gau_sum  = 12'(corners) + 12'({edges, 1'b0}) + 12'({centre, 2'b00});

        out_pos  = 13'({centre, 3'b000});
        out_neg  = 13'(corners) + 13'(edges);
        out_sum  = $signed(out_pos - out_neg);
        if (out_sum < 13'sd1) begin
            out_val = 8'd1;
        end else if (out_sum > 13'sd255) begin
            out_val = 8'd255;
        end else begin
            out_val = out_sum[PIX_W-1:0];
        end

        shp_pos  = 12'({centre, 2'b00}) + 12'(centre);
        shp_sum  = $signed(shp_pos - 12'(edges));
        if (shp_sum < 12'sd0) begin
            shp_val = 8'd0;
        end else if (shp_sum > 12'sd255) begin
            shp_val = 8'd255;
        end else begin
            shp_val = shp_sum[PIX_W-1:0];
        end

        case (i_mode)
            MODE_BOX:     o_value = box_prod[RECIP9_SH+PIX_W-1:RECIP9_SH];
            MODE_GAUSS:   o_value = gau_sum[11:4];
            MODE_OUTLINE: o_value = out_val;
            MODE_SHARPEN: o_value = shp_val;
            default:      o_value = shp_val;
        endcase
    end

endmodule

[rtl/kernel_3x3_convolution_top.sv]
// 3x3 convolution filter on a raster stream of 8-bit grey pixels, one pixel
// per clock. Each pixel is accepted in the cycle it is offered (unless the
// result side stalls); its line-store read and the kernel each take one
// registered stage. Border pixels give no result. The kernel (box, gaussian,
// outline, sharpen) and the row width are set over the APB port while the
// stream is idle. After reset the line stores are cleared one entry per
// cycle, so i_in_valid is held off by o_in_stall until all MAX_WIDTH
// entries (1024 by default) are cleared; register writes are taken during
// that time.
module kernel_3x3_convolution_top import kc3_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PIX_W-1:0]   i_pixel_value,
    input  logic               i_frame_start,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [PIX_W-1:0]   o_filtered_value,
    output logic [POS_W-1:0]   o_center_row,
    output logic [POS_W-1:0]   o_center_col
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > IMG_W_W) ? $clog2(MAX_WIDTH + 1) : IMG_W_W;

    t_cfg cfg;

    logic [CW-1:0]    r_col;
    logic [POS_W-1:0] r_row;

    logic             r_s1_vld;
    logic             r_s1_prod;
    logic [PIX_W-1:0] r_s1_pix;
    logic [CW-1:0]    r_s1_col;
    logic [POS_W-1:0] r_s1_row;
    logic [PIX_W-1:0] r_win [6];

    logic             r_out_vld;
    logic [PIX_W-1:0] r_out_val;
    logic [POS_W-1:0] r_out_row;
    logic [POS_W-1:0] r_out_col;

    logic [WW-1:0]    width_ext;
    logic [WW-1:0]    eff_width;
    logic [CW-1:0]    last_col;
    logic [CW-1:0]    cur_col;
    logic [CW-1:0]    col0;
    logic [POS_W-1:0] row0;
    logic             in_acc;
    logic             s1_move;
    logic             busy;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] kern_val;
    t_win             win;

    kc3_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    always_comb begin
        width_ext = WW'(cfg.image_width);
        if (width_ext < WW'(3)) begin
            eff_width = WW'(3);
        end else if (width_ext > WW'(MAX_WIDTH)) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
        last_col = CW'(eff_width - WW'(1));

        col0 = i_frame_start ? '0 : r_col;
        row0 = i_frame_start ? '0 : r_row;
        cur_col = (col0 > last_col) ? last_col : col0;
    end

    assign s1_move    = r_s1_vld && (!r_s1_prod || !r_out_vld || !i_out_stall);
    assign o_in_stall = busy || (r_s1_vld && !s1_move);
    assign in_acc     = i_in_valid && !o_in_stall;

    kc3_line_buf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (cur_col),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_col),
        .i_wr_pix  (r_s1_pix),
        .o_top     (top),
        .o_mid     (mid),
        .o_busy    (busy)
    );

    // raster position of the next pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (cur_col == last_col) begin
                r_col <= '0;
                r_row <= row0 + 1'b1;
            end else begin
                r_col <= cur_col + 1'b1;
                r_row <= row0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_prod <= (row0 >= POS_W'(2)) && (cur_col >= CW'(2));
            r_s1_pix  <= i_pixel_value;
            r_s1_col  <= cur_col;
            r_s1_row  <= row0 - 1'b1;
        end
    end

    // advance the window by one column
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= top;
            r_win[1] <= mid;
            r_win[2] <= r_s1_pix;
        end
    end

    always_comb begin
        win[0][0] = r_win[3];
        win[1][0] = r_win[4];
        win[2][0] = r_win[5];
        win[0][1] = r_win[0];
        win[1][1] = r_win[1];
        win[2][1] = r_win[2];
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = r_s1_pix;
    end

    kc3_kernel u_kernel (
        .i_mode  (cfg.mode),
        .i_win   (win),
        .o_value (kern_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_move && r_s1_prod) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_prod) begin
            r_out_val <= kern_val;
            r_out_row <= r_s1_row;
            r_out_col <= POS_W'(r_s1_col - CW'(1));
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_filtered_value = r_out_val;
    assign o_center_row     = r_out_row;
    assign o_center_col     = r_out_col;

endmodule
